>>> sv/bb3_pkg.sv
// shared constants, codes and types for the 3x3 rgb box blur
`timescale 1ns / 1ps

package bb3_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;

  localparam int unsigned DimW   = 11;
  localparam int unsigned AddrW  = $clog2(MaxWidth);
  localparam int unsigned ChanW  = 8;
  localparam int unsigned SumW   = 12;
  localparam int unsigned PaddrW = 3;
  localparam int unsigned DataW  = 32;

  localparam logic [DimW-1:0] WidthReset  = 11'd640;
  localparam logic [DimW-1:0] HeightReset = 11'd480;

  // floor(s / d) == (s * Recip) >> RecipShift for every s below 2^SumW
  localparam int unsigned RecipW     = 13;
  localparam int unsigned RecipShift = 15;
  localparam int unsigned ProdW      = SumW + RecipW;
  localparam logic [RecipW-1:0] Recip6 = 13'd5462;
  localparam logic [RecipW-1:0] Recip9 = 13'd3641;

  typedef enum logic {
    RegFrameWidth  = 1'b0,
    RegFrameHeight = 1'b1
  } reg_idx_e;

  typedef enum logic {
    OpPixel = 1'b0,
    OpDrain = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    DivBy4 = 2'd0,
    DivBy6 = 2'd1,
    DivBy9 = 2'd2
  } div_e;

  // index 2 red, 1 green, 0 blue
  typedef logic [2:0][ChanW-1:0] pix_t;

  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
  } dims_t;

  typedef struct packed {
    logic             re;
    logic [AddrW-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    pix_t             two_above;
    pix_t             above;
  } mem_wr_t;

  // word waiting for its line-store read data
  typedef struct packed {
    logic             valid;
    logic             emit;
    logic             col_lo;
    logic             col_hi;
    logic             row_lo;
    logic             row_hi;
    logic             last;
    pix_t             pix;
    logic [AddrW-1:0] idx;
  } item_t;

  // neighborhood sums waiting for the divide
  typedef struct packed {
    logic                 valid;
    logic                 last;
    div_e                 div;
    logic [2:0][SumW-1:0] sum;
  } sum_t;

endpackage

>>> sv/bb3_cfg.sv
// apb register file for frame width and height, with range clamping
`timescale 1ns / 1ps

module bb3_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bb3_pkg::PaddrW-1:0] paddr,
  input  logic [bb3_pkg::DataW-1:0]  pwdata,
  output logic [bb3_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output bb3_pkg::dims_t             dims_o
);
  import bb3_pkg::*;

  logic [DimW-1:0] width_q, width_d;
  logic [DimW-1:0] height_q, height_d;
  logic            wr_en;
  reg_idx_e        sel;

  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v, int unsigned hi);
    logic [DimW-1:0] r;
    r = v;
    if (v < DimW'(2)) r = DimW'(2);
    else if (32'(v) > hi) r = DimW'(hi);
    return r;
  endfunction

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = reg_idx_e'(paddr[2]);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      unique case (sel)
        RegFrameWidth:  width_d  = pwdata[DimW-1:0];
        RegFrameHeight: height_d = pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      RegFrameWidth:  prdata = DataW'(width_q);
      RegFrameHeight: prdata = DataW'(height_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign dims_o.width  = clamp_dim(width_q, MaxWidth);
  assign dims_o.height = clamp_dim(height_q, MaxHeight);

endmodule

>>> sv/bb3_ctrl.sv
// frame position counters, drain bookkeeping and line-store read issue
`timescale 1ns / 1ps

module bb3_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      operation_i,
  input  logic [bb3_pkg::ChanW-1:0] in_red_i,
  input  logic [bb3_pkg::ChanW-1:0] in_green_i,
  input  logic [bb3_pkg::ChanW-1:0] in_blue_i,
  input  bb3_pkg::dims_t            dims_i,
  input  logic                      b_go_i,
  output bb3_pkg::item_t            item_o,
  output bb3_pkg::mem_rd_t          rd_o
);
  import bb3_pkg::*;

  logic [DimW-1:0] col_q, col_d;
  logic [DimW-1:0] row_q, row_d;
  logic [DimW-1:0] drain_q, drain_d;
  item_t           item_q;

  logic            accept, is_drain, ignored, active;
  logic [DimW:0]   col_inc, row_inc;
  logic            col_wrap, row_end, emit, last;
  logic [DimW-1:0] cr, cc;
  logic [AddrW-1:0] idx;
  logic [DimW-1:0] w, h;

  assign w = dims_i.width;
  assign h = dims_i.height;

  assign in_ready_o = !item_q.valid || b_go_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_drain   = (operation_i == OpDrain);
  // a drain with nothing owed, or a pixel while drains are owed, is dropped
  assign ignored    = is_drain ? (drain_q == '0) : (drain_q != '0);
  assign active     = accept && !ignored;

  assign col_inc  = {1'b0, col_q} + (DimW+1)'(1);
  assign row_inc  = {1'b0, row_q} + (DimW+1)'(1);
  assign col_wrap = col_inc >= {1'b0, w};
  assign row_end  = row_inc >= {1'b0, h};

  assign emit = (row_q >= DimW'(2)) || ((row_q == DimW'(1)) && (col_q != '0));

  // center of the result that this word completes
  always_comb begin
    if (col_q != '0) begin
      cr = row_q - DimW'(1);
      cc = col_q - DimW'(1);
    end else begin
      cr = row_q - DimW'(2);
      cc = w - DimW'(1);
    end
  end

  assign idx = (32'(col_q) < MaxWidth) ? col_q[AddrW-1:0] : AddrW'(MaxWidth - 1);

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    drain_d = drain_q;
    last    = 1'b0;
    if (active) begin
      if (is_drain) begin
        drain_d = drain_q - DimW'(1);
        if (drain_q == DimW'(1)) begin
          last  = 1'b1;
          col_d = '0;
          row_d = '0;
        end else if (col_wrap) begin
          col_d = '0;
          row_d = row_q + DimW'(1);
        end else begin
          col_d = col_inc[DimW-1:0];
        end
      end else begin
        if (row_end && col_wrap) drain_d = w + DimW'(1);
        if (col_wrap) begin
          col_d = '0;
          row_d = row_q + DimW'(1);
        end else begin
          col_d = col_inc[DimW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= '0;
      item_q  <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      drain_q <= drain_d;
      if (in_ready_o) item_q.valid <= active;
      if (active) begin
        item_q.emit   <= emit;
        item_q.col_lo <= (cc != '0);
        item_q.col_hi <= (({1'b0, cc} + (DimW+1)'(1)) < {1'b0, w});
        item_q.row_lo <= (cr != '0);
        item_q.row_hi <= (({1'b0, cr} + (DimW+1)'(1)) < {1'b0, h});
        item_q.last   <= last;
        item_q.pix    <= is_drain ? '0 : {in_red_i, in_green_i, in_blue_i};
        item_q.idx    <= idx;
      end
    end
  end

  assign item_o  = item_q;
  assign rd_o.re   = active;
  assign rd_o.addr = idx;

endmodule

>>> sv/bb3_line_mem.sv
// two-row line store in one memory, with same-entry write forwarding
`timescale 1ns / 1ps

module bb3_line_mem (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bb3_pkg::mem_rd_t rd_i,
  input  bb3_pkg::mem_wr_t wr_i,
  output bb3_pkg::pix_t    two_above_o,
  output bb3_pkg::pix_t    above_o
);
  import bb3_pkg::*;

  logic [2*$bits(pix_t)-1:0] mem_q [MaxWidth];
  logic [2*$bits(pix_t)-1:0] rd_q, byp_data_q, rdata;
  logic                      byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) mem_q[wr_i.addr] <= {wr_i.two_above, wr_i.above};
    if (rd_i.re) begin
      rd_q       <= mem_q[rd_i.addr];
      byp_data_q <= {wr_i.two_above, wr_i.above};
    end
  end

  // a read that meets a write to the same entry takes the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_i.re) begin
      byp_q <= wr_i.we && (wr_i.addr == rd_i.addr);
    end
  end

  assign rdata       = byp_q ? byp_data_q : rd_q;
  assign two_above_o = rdata[2*$bits(pix_t)-1:$bits(pix_t)];
  assign above_o     = rdata[$bits(pix_t)-1:0];

endmodule

>>> sv/bb3_window.sv
// 3x3 window, line-store write back and masked neighborhood sums
`timescale 1ns / 1ps

module bb3_window (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bb3_pkg::item_t   item_i,
  input  bb3_pkg::pix_t    two_above_i,
  input  bb3_pkg::pix_t    above_i,
  input  logic             d_ready_i,
  output logic             b_go_o,
  output bb3_pkg::mem_wr_t wr_o,
  output bb3_pkg::sum_t    sum_o
);
  import bb3_pkg::*;

  // window indexed [column][row], column 2 newest, row 2 current line
  pix_t [2:0][2:0]      win_q, win_d;
  sum_t                 sum_q;
  logic                 c_ready, load;
  logic [2:0]           col_en, row_en;
  logic [2:0][SumW-1:0] sum;
  logic                 nc3, nr3;
  div_e                 div;

  assign c_ready = !sum_q.valid || d_ready_i;
  assign b_go_o  = item_i.valid && (!item_i.emit || c_ready);
  assign load    = b_go_o && item_i.emit;

  assign wr_o.we        = b_go_o;
  assign wr_o.addr      = item_i.idx;
  assign wr_o.two_above = above_i;
  assign wr_o.above     = item_i.pix;

  always_comb begin
    win_d[0]    = win_q[1];
    win_d[1]    = win_q[2];
    win_d[2][0] = two_above_i;
    win_d[2][1] = above_i;
    win_d[2][2] = item_i.pix;
  end

  assign col_en = {item_i.col_hi, 1'b1, item_i.col_lo};
  assign row_en = {item_i.row_hi, 1'b1, item_i.row_lo};

  always_comb begin
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      for (int m = 0; m < 3; m++) begin
        if (col_en[k] && row_en[m]) begin
          for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = sum[ch] + SumW'(win_d[k][m][ch]);
          end
        end
      end
    end
  end

  assign nc3 = item_i.col_lo && item_i.col_hi;
  assign nr3 = item_i.row_lo && item_i.row_hi;
  assign div = (nc3 && nr3) ? DivBy9 : ((nc3 || nr3) ? DivBy6 : DivBy4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      sum_q <= '0;
    end else begin
      if (b_go_o) win_q <= win_d;
      if (c_ready) sum_q.valid <= load;
      if (load) begin
        sum_q.last <= item_i.last;
        sum_q.div  <= div;
        sum_q.sum  <= sum;
      end
    end
  end

  assign sum_o = sum_q;

endmodule

>>> sv/bb3_mean.sv
// reciprocal divide by 4, 6 or 9 into the output register
`timescale 1ns / 1ps

module bb3_mean (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bb3_pkg::sum_t             sum_i,
  input  logic                      out_ready_i,
  output logic                      d_ready_o,
  output logic                      out_valid_o,
  output logic [bb3_pkg::ChanW-1:0] out_red_o,
  output logic [bb3_pkg::ChanW-1:0] out_green_o,
  output logic [bb3_pkg::ChanW-1:0] out_blue_o,
  output logic                      frame_last_o
);
  import bb3_pkg::*;

  logic              out_valid_q;
  pix_t              mean_q, mean_d;
  logic              last_q;
  logic [ProdW-1:0]  prod [3];

  assign d_ready_o = !out_valid_q || out_ready_i;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = '0;
      unique case (sum_i.div)
        DivBy4: begin
          mean_d[ch] = sum_i.sum[ch][2 +: ChanW];
        end
        DivBy6: begin
          prod[ch]   = ProdW'(sum_i.sum[ch]) * ProdW'(Recip6);
          mean_d[ch] = prod[ch][RecipShift +: ChanW];
        end
        DivBy9: begin
          prod[ch]   = ProdW'(sum_i.sum[ch]) * ProdW'(Recip9);
          mean_d[ch] = prod[ch][RecipShift +: ChanW];
        end
        default: begin
          mean_d[ch] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mean_q      <= '0;
      last_q      <= 1'b0;
    end else if (d_ready_o) begin
      out_valid_q <= sum_i.valid;
      if (sum_i.valid) begin
        mean_q <= mean_d;
        last_q <= sum_i.last;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_red_o    = mean_q[2];
  assign out_green_o  = mean_q[1];
  assign out_blue_o   = mean_q[0];
  assign frame_last_o = last_q;

endmodule

>>> sv/box_blur_3x3_rgb_top.sv
// top level of the 3x3 rgb box blur
`timescale 1ns / 1ps

// input channel: one word per pixel in raster order (operation 0), then after
//   the frame's last pixel frame_width+1 drain words (operation 1) that push
//   out the results still owed; a drain with nothing owed and a pixel sent
//   while drains are owed are taken and dropped
// output channel: one word per result, the truncated per-channel mean of the
//   in-frame 3x3 neighborhood (9, 6 or 4 pixels); results trail the input by
//   one row plus one pixel, and frame_last marks the frame's final result
// throughput: one word per clock unless out_ready stalls it; the line store
//   has one read and one write port and is read and written once per word
// path: line-store read into the word register, window sum into the sum
//   register, divide into the output register
// stall: when out_ready is low the three pipeline registers keep filling, so
//   in_ready only drops once all of them hold a word
// reset: position counters, drain count and window clear, frame size returns
//   to 640 x 480; the line store is not cleared, its stale entries only ever
//   feed neighbors outside the frame, which are masked
// config: apb writes at byte 0 (width) and 4 (height), only while idle

module box_blur_3x3_rgb_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // apb configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bb3_pkg::PaddrW-1:0] paddr,
  input  logic [bb3_pkg::DataW-1:0]  pwdata,
  output logic [bb3_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  // pixel input
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       operation_i,
  input  logic [bb3_pkg::ChanW-1:0]  in_red_i,
  input  logic [bb3_pkg::ChanW-1:0]  in_green_i,
  input  logic [bb3_pkg::ChanW-1:0]  in_blue_i,
  // result output
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [bb3_pkg::ChanW-1:0]  out_red_o,
  output logic [bb3_pkg::ChanW-1:0]  out_green_o,
  output logic [bb3_pkg::ChanW-1:0]  out_blue_o,
  output logic                       frame_last_o
);
  import bb3_pkg::*;

  dims_t   dims;     // clamped frame size
  item_t   item;     // word waiting on line-store data
  mem_rd_t rd;
  mem_wr_t wr;
  pix_t    two_above, above;
  sum_t    sums;     // word waiting on the divide
  logic    b_go;     // window stage retires a word
  logic    d_ready;  // output register can take a word

  bb3_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dims_o  (dims)
  );

  // counters decide mask, divisor and frame end at accept time
  bb3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .dims_i      (dims),
    .b_go_i      (b_go),
    .item_o      (item),
    .rd_o        (rd)
  );

  // both stored rows share one entry per column
  bb3_line_mem u_line_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_i        (rd),
    .wr_i        (wr),
    .two_above_o (two_above),
    .above_o     (above)
  );

  bb3_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .two_above_i (two_above),
    .above_i     (above),
    .d_ready_i   (d_ready),
    .b_go_o      (b_go),
    .wr_o        (wr),
    .sum_o       (sums)
  );

  bb3_mean u_mean (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sum_i        (sums),
    .out_ready_i  (out_ready_i),
    .d_ready_o    (d_ready),
    .out_valid_o  (out_valid_o),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o),
    .frame_last_o (frame_last_o)
  );

endmodule

>>> verif/box_blur_3x3_rgb_checker.sv
// checker for the 3x3 rgb box blur: tracks the config and input words and checks each result
`timescale 1ns / 1ps

module box_blur_3x3_rgb_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bb3_pkg::PaddrW-1:0] paddr,
  input  logic [bb3_pkg::DataW-1:0]  pwdata,
  input  logic                       pready,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic                       operation_i,
  input  logic [bb3_pkg::ChanW-1:0]  in_red_i,
  input  logic [bb3_pkg::ChanW-1:0]  in_green_i,
  input  logic [bb3_pkg::ChanW-1:0]  in_blue_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [bb3_pkg::ChanW-1:0]  out_red_i,
  input  logic [bb3_pkg::ChanW-1:0]  out_green_i,
  input  logic [bb3_pkg::ChanW-1:0]  out_blue_i,
  input  logic                       frame_last_i,
  output int unsigned                owed_o,
  output int unsigned                mismatches_o
);
  import bb3_pkg::*;

  typedef struct packed {
    pix_t pix;
    logic last;
  } blur_res_t;

  pix_t            line_above     [MaxWidth];
  pix_t            line_two_above [MaxWidth];
  pix_t            win            [9];
  int unsigned     col_q;
  int unsigned     row_q;
  int unsigned     drains_owed;
  logic [DimW-1:0] width_q;
  logic [DimW-1:0] height_q;
  blur_res_t       blurred_q [$];

  function automatic int unsigned eff_dim(logic [DimW-1:0] v, int unsigned hi);
    if (v < DimW'(2)) return 2;
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  function automatic void step_position(int unsigned w);
    if (col_q + 1 >= w) begin
      col_q = 0;
      row_q++;
    end else begin
      col_q++;
    end
  endfunction

  // window shift, line store update, position and drain bookkeeping, then the mean
  task automatic blur_word(input op_e op, input pix_t px_in);
    int unsigned w, h, r, c, idx, cr, cc, n, k, m, ch;
    int unsigned sum [3];
    pix_t        px;
    pix_t        p;
    logic        emit;
    logic        last;
    blur_res_t   res;
    w    = eff_dim(width_q, MaxWidth);
    h    = eff_dim(height_q, MaxHeight);
    r    = row_q;
    c    = col_q;
    last = 1'b0;
    px   = '0;
    if (op == OpDrain) begin
      if (drains_owed == 0) return;
    end else begin
      if (drains_owed != 0) return;
      px = px_in;
    end

    idx = (c < MaxWidth) ? c : MaxWidth - 1;
    for (k = 0; k < 6; k++) win[k] = win[k+3];
    win[6] = line_two_above[idx];
    win[7] = line_above[idx];
    win[8] = px;
    line_two_above[idx] = line_above[idx];
    line_above[idx]     = px;

    emit = (r >= 2) || (r == 1 && c >= 1);
    if (c >= 1) begin
      cr = r - 1;
      cc = c - 1;
    end else begin
      cr = r - 2;
      cc = w - 1;
    end

    if (op == OpDrain) begin
      drains_owed--;
      if (drains_owed == 0) begin
        last  = 1'b1;
        row_q = 0;
        col_q = 0;
      end else begin
        step_position(w);
      end
    end else begin
      if (r + 1 >= h && c + 1 >= w) drains_owed = w + 1;
      step_position(w);
    end

    if (!emit) return;

    // k walks window columns left to right, m walks rows top to bottom
    for (ch = 0; ch < 3; ch++) sum[ch] = 0;
    n = 0;
    for (k = 0; k < 3; k++) begin
      if (k == 0 && cc < 1) continue;
      if (k == 2 && cc + 1 >= w) continue;
      for (m = 0; m < 3; m++) begin
        if (m == 0 && cr < 1) continue;
        if (m == 2 && cr + 1 >= h) continue;
        p = win[k*3 + m];
        for (ch = 0; ch < 3; ch++) sum[ch] += 32'(p[ch]);
        n++;
      end
    end
    if (n == 0) n = 1;
    for (ch = 0; ch < 3; ch++) res.pix[ch] = ChanW'(sum[ch] / n);
    res.last = last;
    blurred_q.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    blur_res_t exp_res;
    pix_t      got_pix;
    if (!rst_ni) begin
      col_q       = 0;
      row_q       = 0;
      drains_owed = 0;
      width_q     = WidthReset;
      height_q    = HeightReset;
      for (int i = 0; i < 9; i++) win[i] = '0;
      blurred_q.delete();
      owed_o       = 0;
      mismatches_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got_pix = {out_red_i, out_green_i, out_blue_i};
        if (blurred_q.size() == 0) begin
          mismatches_o++;
          $display("%0t: expected no result, got r=%02h g=%02h b=%02h last=%0b", $time,
                   out_red_i, out_green_i, out_blue_i, frame_last_i);
        end else begin
          exp_res = blurred_q.pop_front();
          if (exp_res.pix[2] !== got_pix[2] || exp_res.pix[1] !== got_pix[1] ||
              exp_res.pix[0] !== got_pix[0] || exp_res.last !== frame_last_i) begin
            mismatches_o++;
            $display("%0t: expected r=%02h g=%02h b=%02h last=%0b, got r=%02h g=%02h b=%02h last=%0b",
                     $time, exp_res.pix[2], exp_res.pix[1], exp_res.pix[0], exp_res.last,
                     out_red_i, out_green_i, out_blue_i, frame_last_i);
          end
        end
      end

      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[2]))
          RegFrameWidth: begin
            width_q = pwdata[DimW-1:0];
          end
          RegFrameHeight: begin
            height_q = pwdata[DimW-1:0];
          end
          default: begin
          end
        endcase
      end

      if (in_valid_i && in_ready_i)
        blur_word(op_e'(operation_i), {in_red_i, in_green_i, in_blue_i});

      owed_o = blurred_q.size();
    end
  end

endmodule

>>> verif/box_blur_3x3_rgb_top_test.sv
// testbench top for the 3x3 rgb box blur: stimulus, flow control and verdict
`timescale 1ns / 1ps

module box_blur_3x3_rgb_top_test;
  import bb3_pkg::*;

  // no acceptance on any channel for this many cycles ends the run
  localparam int unsigned IdleLimit    = 2000;
  // pipeline is 3 deep, give words that make no result time to leave
  localparam int unsigned SettleCycles = 12;
  // long receiver hold-off, well past what fills the pipeline
  localparam int unsigned HoldCycles   = 80;
  // rough size of the random part, counted in words that the block acts on
  localparam int unsigned RandomWords  = 500;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              operation_i;
  logic [ChanW-1:0]  in_red_i;
  logic [ChanW-1:0]  in_green_i;
  logic [ChanW-1:0]  in_blue_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [ChanW-1:0]  out_red_o;
  logic [ChanW-1:0]  out_green_o;
  logic [ChanW-1:0]  out_blue_o;
  logic              frame_last_o;

  int unsigned owed;
  int unsigned mismatches;

  // flow-control knobs shared between the sender and the receiver
  logic hold_off_req;
  logic rx_steady;
  logic tx_steady;

  int unsigned random_words;

  box_blur_3x3_rgb_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .in_red_i     (in_red_i),
    .in_green_i   (in_green_i),
    .in_blue_i    (in_blue_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o),
    .frame_last_o (frame_last_o)
  );

  box_blur_3x3_rgb_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .operation_i  (operation_i),
    .in_red_i     (in_red_i),
    .in_green_i   (in_green_i),
    .in_blue_i    (in_blue_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_red_i    (out_red_o),
    .out_green_i  (out_green_o),
    .out_blue_i   (out_blue_o),
    .frame_last_i (frame_last_o),
    .owed_o       (owed),
    .mismatches_o (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random pixel, with solid black and solid white mixed in
  function automatic pix_t any_pixel();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 16) return '1;
    return pix_t'($urandom);
  endfunction

  // one word on the input channel; valid stays up across back-to-back words
  task automatic send_word(input op_e op, input pix_t px);
    int unsigned gap;
    gap = tx_steady ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    in_red_i    <= px[2];
    in_green_i  <= px[1];
    in_blue_i   <= px[0];
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // sender goes quiet until every result is out and the pipeline has emptied
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (owed != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // setup cycle, then access cycle; pready is tied high but still honored
  task automatic apb_write(input reg_idx_e idx, input logic [DataW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // raw register values may be out of range, the block clamps them to 2..max
  task automatic set_dims(input logic [DimW-1:0] w_raw, input logic [DimW-1:0] h_raw,
                          output int unsigned w, output int unsigned h);
    apb_write(RegFrameWidth, DataW'(w_raw));
    apb_write(RegFrameHeight, DataW'(h_raw));
    w = (w_raw < DimW'(2)) ? 2 : (32'(w_raw) > MaxWidth) ? MaxWidth : 32'(w_raw);
    h = (h_raw < DimW'(2)) ? 2 : (32'(h_raw) > MaxHeight) ? MaxHeight : 32'(h_raw);
  endtask

  // pixels with the odd stray drain, which the block drops since nothing is owed yet
  task automatic send_pixels(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 99) < 3) send_word(OpDrain, any_pixel());
      send_word(OpPixel, any_pixel());
    end
  endtask

  // drains with the odd stray pixel in between, and sometimes one drain too many
  task automatic send_drains(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_word(OpDrain, any_pixel());
      if (i + 1 < count && $urandom_range(0, 99) < 3) send_word(OpPixel, any_pixel());
    end
    if ($urandom_range(0, 99) < 15) send_word(OpDrain, any_pixel());
  endtask

  task automatic stream_frame(input int unsigned w, input int unsigned h);
    send_pixels(w * h);
    send_drains(w + 1);
    random_words += w * h + w + 1;
    wait_drained();
  endtask

  // receiver: random stalls, steady stretches, and the long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    stall       = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else if (stall != 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        if (!rx_steady && $urandom_range(0, 99) < 30) stall = pick_gap();
      end
    end
  end

  // watchdog on forward progress
  initial begin : progress_watch
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
        quiet = 0;
      else
        quiet++;
      if (quiet >= IdleLimit) begin
        $display("box_blur_3x3_rgb_top: mismatch");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned w, h, wb, hb, phase;
    logic [DimW-1:0] w_raw, h_raw;
    pix_t px;

    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    operation_i  = OpPixel;
    in_red_i     = '0;
    in_green_i   = '0;
    in_blue_i    = '0;
    hold_off_req = 1'b0;
    rx_steady    = 1'b1;
    tx_steady    = 1'b1;
    random_words = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: 3x3 frame, so the center sees all nine neighbors, edges six, corners four
    set_dims(DimW'(3), DimW'(3), w, h);
    send_word(OpDrain, '1);            // drain with nothing owed, dropped
    for (int i = 0; i < 9; i++) begin
      px[2] = (i % 2 == 1) ? 8'hff : 8'h00;
      px[1] = (i % 3 == 0) ? 8'hff : 8'h00;
      px[0] = (i == 4) ? 8'hff : ChanW'(i * 37);
      send_word(OpPixel, px);
    end
    send_word(OpPixel, '1);            // pixel while drains are owed, dropped
    for (int i = 0; i < 4; i++) send_word(OpDrain, '0);
    send_word(OpDrain, '0);            // one drain past the frame's end, dropped
    wait_drained();

    // directed: smallest frame, every result is a four-pixel mean
    set_dims(DimW'(2), DimW'(2), w, h);
    send_word(OpPixel, '1);
    send_word(OpPixel, '0);
    send_word(OpPixel, '1);
    send_word(OpPixel, {8'h01, 8'hfe, 8'h80});
    for (int i = 0; i < 3; i++) send_word(OpDrain, '1);
    wait_drained();

    // random frames, mostly small, with a split frame and a pressure run mixed in;
    // the loop always reaches both of those before it stops
    phase = 0;
    while (random_words < RandomWords || phase < 6) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      case (phase % 8)
        3: begin
          // size changes after row 0, while nothing is owed; width only shrinks so
          // every stored entry the rest of the frame reads was written in this frame
          set_dims(DimW'($urandom_range(4, 10)), DimW'($urandom_range(2, 6)), w, h);
          send_pixels(w);
          random_words += w;
          wait_drained();
          wb = $urandom_range(2, w - 1);
          hb = $urandom_range(2, 6);
          apb_write(RegFrameWidth, DataW'(wb));
          apb_write(RegFrameHeight, DataW'(hb));
          send_pixels((hb - 1) * wb);
          send_drains(wb + 1);
          random_words += (hb - 1) * wb + wb + 1;
          wait_drained();
        end
        5: begin
          // receiver holds off while the sender streams, so the input stalls
          set_dims(DimW'(16), DimW'(10), w, h);
          tx_steady    = 1'b1;
          hold_off_req = 1'b1;
          stream_frame(w, h);
        end
        default: begin
          case ($urandom_range(0, 9))
            0:       w_raw = DimW'($urandom_range(0, 1));
            1:       w_raw = DimW'($urandom_range(13, 40));
            default: w_raw = DimW'($urandom_range(2, 12));
          endcase
          h_raw = ($urandom_range(0, 9) == 0) ? DimW'($urandom_range(0, 1))
                                              : DimW'($urandom_range(2, 8));
          set_dims(w_raw, h_raw, w, h);
          stream_frame(w, h);
        end
      endcase
      phase++;
    end

    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);
    if (mismatches == 0 && owed == 0)
      $display("box_blur_3x3_rgb_top: match");
    else
      $display("box_blur_3x3_rgb_top: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
sv/bb3_pkg.sv
sv/bb3_cfg.sv
sv/bb3_ctrl.sv
sv/bb3_line_mem.sv
sv/bb3_window.sv
sv/bb3_mean.sv
sv/box_blur_3x3_rgb_top.sv
verif/box_blur_3x3_rgb_checker.sv
verif/box_blur_3x3_rgb_top_test.sv
